[src/ewt_pkg.sv]
// shared types, character codes and field helpers for the encoded word tokenizer
package ewt_pkg;

    localparam int TOKEN_POS_W  = 10;
    localparam int TOKEN_LEN_W  = 11;
    localparam int CHARSET_LEN_W = 6;

    localparam logic [CHARSET_LEN_W-1:0] CHARSET_CAP = 6'd63;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_B64   = 2'd1;
    localparam logic [1:0] KIND_QP    = 2'd2;

    localparam logic [7:0] CHR_EQUALS = 8'h3D;
    localparam logic [7:0] CHR_QMARK  = 8'h3F;
    localparam logic [7:0] CHR_UPPER_B = 8'h42;
    localparam logic [7:0] CHR_LOWER_B = 8'h62;
    localparam logic [7:0] CHR_UPPER_Q = 8'h51;
    localparam logic [7:0] CHR_LOWER_Q = 8'h71;

    typedef struct packed {
        logic [1:0]               kind;
        logic [TOKEN_POS_W-1:0]   start;
        logic [TOKEN_LEN_W-1:0]   length;
        logic [TOKEN_POS_W-1:0]   cs_start;
        logic [CHARSET_LEN_W-1:0] cs_length;
        logic                     run_last;
        logic                     line_final;
    } tok_result_t;

    // handshake status from the result buffer back to the scanner
    typedef struct packed {
        logic can_load;
    } ewt_buf_status_t;

    function automatic logic [TOKEN_POS_W-1:0] fit_pos(input logic [31:0] v);
        return v[TOKEN_POS_W-1:0];
    endfunction

    function automatic logic [TOKEN_LEN_W-1:0] fit_len(input logic [31:0] v);
        return v[TOKEN_LEN_W-1:0];
    endfunction

endpackage

[src/ewt_out_buf.sv]
// two-entry result buffer feeding the master side
module ewt_out_buf
    import ewt_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  logic [1:0]      load_cnt,
    input  tok_result_t     load0,
    input  tok_result_t     load1,
    input  logic            m_tready,
    output logic            m_tvalid,
    output tok_result_t     head,
    output ewt_buf_status_t status
);

    logic [1:0]  cnt_reg;
    tok_result_t slot0_reg;
    tok_result_t slot1_reg;
    logic        pop;

    assign pop      = (cnt_reg != 2'd0) && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign head     = slot0_reg;

    // a new pair may be loaded once the buffer drains this cycle
    assign status.can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= load_cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= load0;
            slot1_reg <= load1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

[src/encoded_word_tokenizer.sv]
// top level of the encoded word tokenizer: byte scanner and result stage
//
//  channel | dir | beat carries                          | ends with
//  s_      | in  | one header byte                       | s_tlast on final byte
//  m_      | out | one token (offset, length, charset)   | m_tlast on last token
//
// one beat enters an input register, short logic scans it against the
// match window and loads up to two token beats into the result buffer
// a byte that yields at most one token sustains one beat per cycle while m_tready
// stays high; a byte that closes a word yields two and holds the input until the result buffer can take a new load
// s_tready drops only while the result buffer is still holding tokens
// that m_tready has not taken
// aresetn (synchronous, active low) returns the scanner to the start of a line
module encoded_word_tokenizer
    import ewt_pkg::*;
#(
    parameter int MAX_LINE  = 1024,
    parameter int MAX_WORDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value [7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_start [9:0], token_length [20:10], charset_start [30:21],
    // charset_length [36:31], zero [39:37]
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,   // token_kind [1:0], run_last [2]
    output logic        m_tlast    // line_final
);

    localparam int POS_W  = $clog2(MAX_LINE + 1);
    localparam int OFF_W  = $clog2(MAX_LINE);
    localparam int CW     = POS_W + 1;
    localparam int WCNT_W = $clog2(MAX_WORDS + 1);

    typedef enum logic [1:0] {
        MODE_OPEN,
        MODE_MARK,
        MODE_CLOSE
    } mode_t;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // scanner state
    mode_t             mode_reg,    mode_next;
    logic [15:0]       window_reg,  window_next;
    logic [1:0]        fill_reg,    fill_next;
    logic [POS_W-1:0]  bpos_reg,    bpos_next;
    logic [POS_W-1:0]  plain_reg,   plain_next;
    logic [OFF_W-1:0]  open_reg,    open_next;
    logic [OFF_W-1:0]  marker_reg,  marker_next;
    logic              enc_reg,     enc_next;
    logic [WCNT_W-1:0] words_reg,   words_next;
    logic              halted_reg,  halted_next;

    logic            advance;
    ewt_buf_status_t buf_status;
    tok_result_t     res0;
    tok_result_t     res1;
    tok_result_t     head;
    logic [1:0]      nres;

    // scan helpers
    logic             in_range;
    logic [OFF_W-1:0] pos;
    logic [7:0]       p1;
    logic [7:0]       p2;
    logic             is_b;
    logic             is_q;
    logic [CW-1:0]    cs_off;
    logic [CW-1:0]    cs_len_full;
    logic [CW-1:0]    data_off;
    logic [CW-1:0]    close_at;
    logic [CW-1:0]    word_len;
    logic [CW-1:0]    lead_len;
    logic [POS_W-1:0] line_end;
    logic [5:0]       cs_len_sat;

    assign advance  = in_valid_reg && buf_status.can_load;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign in_range = bpos_reg < POS_W'(MAX_LINE);
    assign pos      = bpos_reg[OFF_W-1:0];
    assign p1       = window_reg[7:0];
    assign p2       = window_reg[15:8];
    assign is_b     = (p1 == CHR_UPPER_B) || (p1 == CHR_LOWER_B);
    assign is_q     = (p1 == CHR_UPPER_Q) || (p1 == CHR_LOWER_Q);

    // offsets of a word that closes on this byte
    assign cs_off      = CW'(open_reg) + CW'(2);
    assign cs_len_full = CW'(marker_reg) - cs_off;
    assign data_off    = CW'(marker_reg) + CW'(3);
    assign close_at    = CW'(pos) - CW'(1);
    assign word_len    = close_at - data_off;
    assign lead_len    = CW'(open_reg) - CW'(plain_reg);
    assign cs_len_sat  = (cs_len_full > CW'(CHARSET_CAP)) ? CHARSET_CAP
                                                          : cs_len_full[5:0];
    assign line_end    = in_range ? (bpos_reg + POS_W'(1)) : POS_W'(MAX_LINE);

    always_comb begin
        logic hit;
        logic closed;
        logic [WCNT_W-1:0] words_inc;

        mode_next   = mode_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        bpos_next   = bpos_reg;
        plain_next  = plain_reg;
        open_next   = open_reg;
        marker_next = marker_reg;
        enc_next    = enc_reg;
        words_next  = words_reg;
        halted_next = halted_reg;
        hit         = 1'b0;
        closed      = 1'b0;
        words_inc   = words_reg + WCNT_W'(1);
        res0        = '0;
        res1        = '0;
        nres        = 2'd0;

        if (in_range) begin
            if (!halted_reg) begin
                case (mode_reg)
                    MODE_OPEN: begin
                        if (in_byte_reg == CHR_QMARK && fill_reg >= 2'd1 &&
                            p1 == CHR_EQUALS) begin
                            open_next = pos - OFF_W'(1);
                            mode_next = MODE_MARK;
                            hit       = 1'b1;
                        end
                    end
                    MODE_MARK: begin
                        if (in_byte_reg == CHR_QMARK && fill_reg >= 2'd2 &&
                            p2 == CHR_QMARK && (is_b || is_q)) begin
                            marker_next = pos - OFF_W'(2);
                            enc_next    = is_q;
                            mode_next   = MODE_CLOSE;
                            hit         = 1'b1;
                        end
                    end
                    MODE_CLOSE: begin
                        if (in_byte_reg == CHR_EQUALS && fill_reg >= 2'd1 &&
                            p1 == CHR_QMARK) begin
                            // plain span in front of the word, then the word
                            res0.kind      = KIND_PLAIN;
                            res0.start     = fit_pos(32'(plain_reg));
                            res0.length    = fit_len(32'(lead_len));
                            res1.kind      = enc_reg ? KIND_QP : KIND_B64;
                            res1.start     = fit_pos(32'(data_off));
                            res1.length    = fit_len(32'(word_len));
                            res1.cs_start  = fit_pos(32'(cs_off));
                            res1.cs_length = cs_len_sat;
                            nres           = 2'd2;
                            plain_next     = POS_W'(pos) + POS_W'(1);
                            mode_next      = MODE_OPEN;
                            words_next     = words_inc;
                            if (words_inc == WCNT_W'(MAX_WORDS)) begin
                                halted_next = 1'b1;
                            end
                            closed = 1'b1;
                            hit    = 1'b1;
                        end
                    end
                    default: begin
                        mode_next = MODE_OPEN;
                    end
                endcase
                // a byte that completes a match never serves the next one
                if (hit) begin
                    window_next = '0;
                    fill_next   = 2'd0;
                end else begin
                    window_next = {window_reg[7:0], in_byte_reg};
                    if (fill_reg < 2'd2) begin
                        fill_next = fill_reg + 2'd1;
                    end
                end
            end
            bpos_next = bpos_reg + POS_W'(1);
        end

        if (in_last_reg) begin
            if (closed) begin
                res1.line_final = 1'b1;
            end else if (!halted_next && plain_next < line_end) begin
                // trailing plain text up to the line end
                res0.kind       = KIND_PLAIN;
                res0.start      = fit_pos(32'(plain_next));
                res0.length     = fit_len(32'(line_end - plain_next));
                res0.line_final = 1'b1;
                nres            = 2'd1;
            end
            mode_next   = MODE_OPEN;
            window_next = '0;
            fill_next   = 2'd0;
            bpos_next   = '0;
            plain_next  = '0;
            open_next   = '0;
            marker_next = '0;
            enc_next    = 1'b0;
            words_next  = '0;
            halted_next = 1'b0;
        end

        if (nres == 2'd2) begin
            res1.run_last = 1'b1;
        end else if (nres == 2'd1) begin
            res0.run_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_OPEN;
            window_reg <= '0;
            fill_reg   <= 2'd0;
            bpos_reg   <= '0;
            plain_reg  <= '0;
            open_reg   <= '0;
            marker_reg <= '0;
            enc_reg    <= 1'b0;
            words_reg  <= '0;
            halted_reg <= 1'b0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            bpos_reg   <= bpos_next;
            plain_reg  <= plain_next;
            open_reg   <= open_next;
            marker_reg <= marker_next;
            enc_reg    <= enc_next;
            words_reg  <= words_next;
            halted_reg <= halted_next;
        end
    end

    // result buffer: holds the one or two token beats of a byte
    ewt_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && (nres != 2'd0)),
        .load_cnt (nres),
        .load0    (res0),
        .load1    (res1),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .head     (head),
        .status   (buf_status)
    );

    assign m_tdata = {3'b000, head.cs_length, head.cs_start, head.length, head.start};
    assign m_tuser = {head.run_last, head.kind};
    assign m_tlast = head.line_final;

endmodule
